### design/c8bfd_pkg.sv
// ----------------------------------------------------------------------------
// c8bfd_pkg
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// ----------------------------------------------------------------------------
package c8bfd_pkg;

  localparam int FRAME_LEN  = 14;
  localparam int IDX_W      = 4;   // index into the 14-byte window
  localparam int CRC_FIRST  = 2;
  localparam int CRC_BYTES  = 11;
  localparam int DIP_POS    = 10;
  localparam int BTN_HI_POS = 11;
  localparam int BTN_LO_POS = 12;
  localparam int CRC_POS    = 13;

  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'hBB;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;

  localparam logic signed [1:0] DIR_ZERO = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // store the accepted beat in the window
    logic drop_one;   // no header: shift out the oldest byte
    logic crc_clear;  // header found: start the CRC pass
    logic crc_step;   // fold one window byte into the CRC
    logic finish;     // load the result, update totals, consume bytes
  } c8bfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;  // window holds 13 bytes, next beat completes it
    logic hdr_match;  // first two bytes match the header registers
    logic crc_last;   // current CRC step folds the last byte
    logic out_busy;   // result register full and stalled
  } c8bfd_stat_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/crc8_button_frame_deframer.sv
// Sequence: a beat that does not complete a 14-byte window is stored; one that
// completes a window with no header adds the header test; one that completes a
// header-aligned frame adds the header test, 11 CRC byte steps at one byte per
// cycle and the result load. Throughput: one byte per cycle while idle; intake
// stalls from a window-completing byte until the block is idle again, with any
// wait for a held result. Reset (rst, synchronous): window empty, totals cleared.
// ----------------------------------------------------------------------------
// crc8_button_frame_deframer
// Header-synchronized 14-byte frame parser with CRC-8 (poly 0x07) check,
// producing button, DIP and clamp direction results per aligned frame.
// ----------------------------------------------------------------------------
module crc8_button_frame_deframer (
  input  logic                             clk,
  input  logic                             rst,
  // byte input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             homing_done,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [c8bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_good,
  output logic [7:0]                       dip_byte,
  output logic [15:0]                      buttons,
  output logic [15:0]                      released_buttons,
  output logic                             drive_update,
  output logic signed [1:0]                out_dir,
  output logic signed [1:0]                yaw_dir,
  output logic signed [1:0]                roll_dir,
  output logic [31:0]                      good_frame_count,
  output logic [31:0]                      bad_frame_count
);
  import c8bfd_pkg::*;

  c8bfd_cmd_t  cmd;
  c8bfd_stat_t st;

  // Header registers take a write beat on any cycle; an index past the
  // register list is accepted and dropped.
  assign cfg_ready = 1'b1;

  // Controller: takes a byte beat only in its idle state, walks the header
  // test and CRC pass, and waits for a free result register before finishing.
  c8bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: window shifts by one on a missing header, by two on a CRC
  // mismatch, and empties on a good frame. The result register sits apart
  // from the intake, so new bytes flow while a result waits for the sink.
  c8bfd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .rx_byte          (rx_byte),
    .homing_done      (homing_done),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_good       (frame_good),
    .dip_byte         (dip_byte),
    .buttons          (buttons),
    .released_buttons (released_buttons),
    .drive_update     (drive_update),
    .out_dir          (out_dir),
    .yaw_dir          (yaw_dir),
    .roll_dir         (roll_dir),
    .good_frame_count (good_frame_count),
    .bad_frame_count  (bad_frame_count)
  );

endmodule

### design/c8bfd_ctrl.sv
// ----------------------------------------------------------------------------
// c8bfd_ctrl
// Sequencer: byte intake, header test, CRC pass and result hand-off.
// ----------------------------------------------------------------------------
module c8bfd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  c8bfd_pkg::c8bfd_stat_t st,
  output c8bfd_pkg::c8bfd_cmd_t  cmd
);
  import c8bfd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_CRC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && st.fill_last) begin
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        if (st.hdr_match) begin
          cmd.crc_clear = 1'b1;
          state_next    = S_CRC;
        end else begin
          cmd.drop_one = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (st.crc_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register can take a new beat
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/c8bfd_dp.sv
// ----------------------------------------------------------------------------
// c8bfd_dp
// Byte window, CRC accumulator, header registers, totals and result register.
// ----------------------------------------------------------------------------
module c8bfd_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  c8bfd_pkg::c8bfd_cmd_t            cmd,
  output c8bfd_pkg::c8bfd_stat_t           st,
  input  logic [7:0]                       rx_byte,
  input  logic                             homing_done,
  input  logic                             cfg_valid,
  input  logic [c8bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_good,
  output logic [7:0]                       dip_byte,
  output logic [15:0]                      buttons,
  output logic [15:0]                      released_buttons,
  output logic                             drive_update,
  output logic signed [1:0]                out_dir,
  output logic signed [1:0]                yaw_dir,
  output logic signed [1:0]                roll_dir,
  output logic [31:0]                      good_frame_count,
  output logic [31:0]                      bad_frame_count
);
  import c8bfd_pkg::*;

  logic [7:0]       window [FRAME_LEN];
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] crc_idx;
  logic [7:0]       crc_acc;
  logic             homing;
  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [15:0]      last_buttons;
  logic [31:0]      good_total;
  logic [31:0]      bad_total;

  logic [15:0]      cur;
  logic             crc_ok;
  logic [IDX_W-1:0] rd_idx;

  assign cur    = {window[BTN_HI_POS], window[BTN_LO_POS]};
  assign crc_ok = (crc_acc == window[CRC_POS]);
  assign rd_idx = crc_idx + IDX_W'(CRC_FIRST);

  assign st.fill_last = (fill == IDX_W'(FRAME_LEN - 1));
  assign st.hdr_match = (window[0] == header_first) && (window[1] == header_second);
  assign st.crc_last  = (crc_idx == IDX_W'(CRC_BYTES - 1));
  assign st.out_busy  = out_valid && out_stall;

  // header registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HDR_FIRST_RST;
      header_second <= HDR_SECOND_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEADER_FIRST) begin
        header_first <= cfg_data;
      end
      if (cfg_index == REG_HEADER_SECOND) begin
        header_second <= cfg_data;
      end
    end
  end

  // window contents: append, shift by one or by two
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      window[fill] <= rx_byte;
      homing       <= homing_done;
    end else if (cmd.drop_one) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
    end else if (cmd.finish && !crc_ok) begin
      for (int i = 0; i < FRAME_LEN - 2; i++) begin
        window[i] <= window[i+2];
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.take) begin
      fill <= fill + 1'b1;
    end else if (cmd.drop_one) begin
      fill <= fill - 1'b1;
    end else if (cmd.finish) begin
      fill <= crc_ok ? '0 : IDX_W'(FRAME_LEN - 2);
    end
  end

  // CRC pass, one byte per cycle
  always_ff @(posedge clk) begin
    if (cmd.crc_clear) begin
      crc_acc <= '0;
      crc_idx <= '0;
    end else if (cmd.crc_step) begin
      crc_acc <= crc8_byte(crc_acc, window[rd_idx]);
      crc_idx <= crc_idx + 1'b1;
    end
  end

  // totals and button history
  always_ff @(posedge clk) begin
    if (rst) begin
      good_total   <= '0;
      bad_total    <= '0;
      last_buttons <= '0;
    end else if (cmd.finish) begin
      if (crc_ok) begin
        good_total   <= good_total + 1'b1;
        last_buttons <= cur;
      end else begin
        bad_total <= bad_total + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      frame_good       <= crc_ok;
      dip_byte         <= '0;
      buttons          <= '0;
      released_buttons <= '0;
      drive_update     <= 1'b0;
      out_dir          <= DIR_ZERO;
      yaw_dir          <= DIR_ZERO;
      roll_dir         <= DIR_ZERO;
      good_frame_count <= crc_ok ? good_total + 1'b1 : good_total;
      bad_frame_count  <= crc_ok ? bad_total : bad_total + 1'b1;
      if (crc_ok) begin
        dip_byte         <= window[DIP_POS];
        buttons          <= cur;
        released_buttons <= last_buttons & ~cur;
        if (homing) begin
          drive_update <= 1'b1;
          out_dir      <= cur[4] ? DIR_NEG : (cur[5] ? DIR_POS : DIR_ZERO);
          yaw_dir      <= cur[0] ? DIR_POS : (cur[8] ? DIR_NEG : DIR_ZERO);
          roll_dir     <= cur[1] ? DIR_NEG : (cur[9] ? DIR_POS : DIR_ZERO);
        end
      end
    end
  end

endmodule

### verif/tb_crc8_button_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_crc8_button_frame_deframer
// Self-checking bench for the header-synced CRC-8 frame deframer. Streams
// good, corrupted and cut-short frames mixed with line noise under several
// header settings, predicts every frame result in a scoreboard, and compares
// each result field by field.
// ----------------------------------------------------------------------------
module tb_crc8_button_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import c8bfd_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 24;      // margin for a no-header shift in flight
  localparam int HOLD_CYCLES   = 400;     // long result back-pressure stretch
  localparam int LIMIT_CYCLES  = 400000;
  localparam int PHASE_BEATS   = 200;

  // Index past the end of the register list: the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // One frame result as seen on the output channel.
  typedef struct packed {
    logic              good;
    logic [7:0]        dip;
    logic [15:0]       btn;
    logic [15:0]       released;
    logic              drive;
    logic signed [1:0] out_d;
    logic signed [1:0] yaw_d;
    logic signed [1:0] roll_d;
    logic [31:0]       good_cnt;
    logic [31:0]       bad_cnt;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadows the byte window, the header registers, the button
  // history and the totals, and queues the frame result each beat causes.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]    hdr_first;
    logic [7:0]    hdr_second;
    logic [7:0]    win [FRAME_LEN];
    int unsigned   fill;
    logic [15:0]   last_btn;
    logic [31:0]   good_total;
    logic [31:0]   bad_total;
    frame_result_t frames_due [$];
    int unsigned   errors, checked, good_seen, bad_seen, drive_seen;

    function new();
      hdr_first  = HDR_FIRST_RST;
      hdr_second = HDR_SECOND_RST;
      fill       = 0;
      last_btn   = '0;
      good_total = '0;
      bad_total  = '0;
      errors     = 0;
      checked    = 0;
      good_seen  = 0;
      bad_seen   = 0;
      drive_seen = 0;
    endfunction

    // Serial MSB-first form of CRC-8 poly 0x07: shift one data bit per step.
    static function logic [7:0] crc8_fold(logic [7:0] acc, logic [7:0] data);
      logic [7:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
        if (r[7] ^ data[i]) begin
          r = {r[6:0], 1'b0} ^ CRC_POLY;
        end else begin
          r = {r[6:0], 1'b0};
        end
      end
      return r;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_HEADER_FIRST: hdr_first = data;
        REG_HEADER_SECOND: hdr_second = data;
        default: ;
      endcase
    endfunction

    function void consume(int unsigned n);
      for (int unsigned i = 0; i + n < fill; i++) win[i] = win[i + n];
      fill = fill - n;
    endfunction

    function logic signed [1:0] pick_dir(logic first_set, logic signed [1:0] first_val,
                                         logic second_set, logic signed [1:0] second_val);
      if (first_set) return first_val;
      if (second_set) return second_val;
      return DIR_ZERO;
    endfunction

    function void note_beat(logic [7:0] data, logic homing);
      frame_result_t r;
      logic [7:0]    crc;
      logic [15:0]   cur;
      win[fill] = data;
      fill++;
      if (fill < FRAME_LEN) return;
      if (win[0] != hdr_first || win[1] != hdr_second) begin
        consume(1);
        return;
      end
      crc = '0;
      for (int i = CRC_FIRST; i < CRC_FIRST + CRC_BYTES; i++) crc = crc8_fold(crc, win[i]);
      r = '0;
      if (crc == win[CRC_POS]) begin
        cur        = {win[BTN_HI_POS], win[BTN_LO_POS]};
        good_total = good_total + 1;
        r.good     = 1'b1;
        r.dip      = win[DIP_POS];
        r.btn      = cur;
        r.released = last_btn & ~cur;
        if (homing) begin
          r.drive  = 1'b1;
          r.out_d  = pick_dir(cur[4], DIR_NEG, cur[5], DIR_POS);
          r.yaw_d  = pick_dir(cur[0], DIR_POS, cur[8], DIR_NEG);
          r.roll_d = pick_dir(cur[1], DIR_NEG, cur[9], DIR_POS);
        end
        last_btn = cur;
        consume(FRAME_LEN);
      end else begin
        bad_total = bad_total + 1;
        consume(2);
      end
      r.good_cnt = good_total;
      r.bad_cnt  = bad_total;
      frames_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (frames_due.size() == 0) begin
        report("frame result with no frame pending");
        return;
      end
      want = frames_due.pop_front();
      checked++;
      if (want.good) good_seen++; else bad_seen++;
      if (want.drive) drive_seen++;
      check_field("frame_good", got.good, want.good);
      check_field("dip_byte", got.dip, want.dip);
      check_field("buttons", got.btn, want.btn);
      check_field("released_buttons", got.released, want.released);
      check_field("drive_update", got.drive, want.drive);
      check_field("out_dir", got.out_d, want.out_d);
      check_field("yaw_dir", got.yaw_d, want.yaw_d);
      check_field("roll_dir", got.roll_d, want.roll_d);
      check_field("good_frame_count", got.good_cnt, want.good_cnt);
      check_field("bad_frame_count", got.bad_cnt, want.bad_cnt);
    endtask

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            rx_byte;
  logic                  homing_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [7:0]            cfg_data;
  logic                  out_valid;
  logic                  out_stall;
  logic                  frame_good;
  logic [7:0]            dip_byte;
  logic [15:0]           buttons;
  logic [15:0]           released_buttons;
  logic                  drive_update;
  logic signed [1:0]     out_dir;
  logic signed [1:0]     yaw_dir;
  logic signed [1:0]     roll_dir;
  logic [31:0]           good_frame_count;
  logic [31:0]           bad_frame_count;

  frame_scoreboard sb = new();

  int unsigned burst_left;     // beats left in the current sender burst
  int unsigned beats_sent;
  int unsigned settings_used;
  bit          hold_req;       // ask the receiver for one long hold-off

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  crc8_button_frame_deframer dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .homing_done      (homing_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_good       (frame_good),
    .dip_byte         (dip_byte),
    .buttons          (buttons),
    .released_buttons (released_buttons),
    .drive_update     (drive_update),
    .out_dir          (out_dir),
    .yaw_dir          (yaw_dir),
    .roll_dir         (roll_dir),
    .good_frame_count (good_frame_count),
    .bad_frame_count  (bad_frame_count)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one byte beat. Bursts of random length alternate with random gaps;
  // valid stays high across a burst and the payload holds while stalled.
  task automatic send_beat(logic [7:0] data, logic homing);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    rx_byte     <= data;
    homing_done <= homing;
    // Hold until the block takes the beat.
    do @(posedge clk); while (in_stall);
    sb.note_beat(data, homing);
    beats_sent++;
  endtask

  // Build a 14-byte frame with a correct CRC, optionally flip one bit after
  // the header, and send its first 'keep' bytes. Homing mode: 0 and 1 force
  // homing_done, anything else randomizes it per beat (mostly high).
  task automatic send_frame(logic [7:0] h1, logic [7:0] h2, logic [7:0] dip,
                            logic [15:0] btn, bit corrupt, int unsigned keep,
                            int homing_mode);
    logic [7:0]  bytes [FRAME_LEN];
    logic [7:0]  crc;
    int unsigned pos;
    logic        hd;
    bytes[0] = h1;
    bytes[1] = h2;
    for (int i = CRC_FIRST; i < DIP_POS; i++) bytes[i] = 8'($urandom);
    bytes[DIP_POS]    = dip;
    bytes[BTN_HI_POS] = btn[15:8];
    bytes[BTN_LO_POS] = btn[7:0];
    crc = '0;
    for (int i = CRC_FIRST; i < CRC_FIRST + CRC_BYTES; i++) begin
      crc = frame_scoreboard::crc8_fold(crc, bytes[i]);
    end
    bytes[CRC_POS] = crc;
    // A single flipped bit is always caught by this CRC.
    if (corrupt) begin
      pos = $urandom_range(CRC_FIRST, CRC_POS);
      bytes[pos] = bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < keep; i++) begin
      if (homing_mode == 0) hd = 1'b0;
      else if (homing_mode == 1) hd = 1'b1;
      else hd = ($urandom_range(0, 3) != 0);
      send_beat(bytes[i], hd);
    end
  endtask

  // Button masks: fully random, only direction bits, or all set / all clear.
  function automatic logic [15:0] rand_buttons();
    case ($urandom_range(0, 3))
      0: return 16'($urandom) & 16'h0333;
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames with random content; the rest corrupted frames,
  // cut-short frames and noise (some of it false header starts).
  task automatic random_phase(int unsigned n_beats);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(sb.hdr_first, sb.hdr_second, 8'($urandom), rand_buttons(), 1'b0,
                   FRAME_LEN, 2);
      end else if (pick < 80) begin
        send_frame(sb.hdr_first, sb.hdr_second, 8'($urandom), rand_buttons(), 1'b1,
                   FRAME_LEN, 2);
      end else if (pick < 90) begin
        send_frame(sb.hdr_first, sb.hdr_second, 8'($urandom), rand_buttons(), 1'b0,
                   $urandom_range(2, FRAME_LEN - 1), 2);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat($urandom_range(0, 1) ? sb.hdr_first : 8'($urandom), 1'($urandom));
        end
      end
    end
    // Drop valid so the last beat is not taken twice.
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
  endtask

  // Wait until every predicted frame has come out, then let any no-header
  // shift still in flight finish.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic new_setting(logic [7:0] h1, logic [7:0] h2);
    settle();
    cfg_write(REG_HEADER_FIRST, h1);
    cfg_write(REG_HEADER_SECOND, h2);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: stall pattern and result check
  // --------------------------------------------------------------------------

  // Stall modes are redrawn when each random-length mode period runs out; a hold
  // request overrides them for a long stretch so the block backs up and stalls its input.
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned tick;
    stall_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    tick      = 0;
    mode      = STALL_NONE;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Take each accepted result beat and check it against the oldest frame.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(frame_result_t'{good: frame_good, dip: dip_byte, btn: buttons,
                                      released: released_buttons, drive: drive_update,
                                      out_d: out_dir, yaw_d: yaw_dir, roll_d: roll_dir,
                                      good_cnt: good_frame_count,
                                      bad_cnt: bad_frame_count});
    end
  end

  // Hard stop if the run hangs.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("crc8_button_frame_deframer regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    rx_byte       = '0;
    homing_done   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_HEADER_FIRST;
    cfg_data      = '0;
    burst_left    = 0;
    beats_sent    = 0;
    settings_used = 1;
    hold_req      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a stray byte ahead of the header gets dropped, then a good
    // frame with every button and DIP bit set under homing (direction
    // precedence), then a corrupted frame with homing low.
    send_beat(8'h00, 1'b0);
    send_frame(HDR_FIRST_RST, HDR_SECOND_RST, 8'hFF, 16'hFFFF, 1'b0, FRAME_LEN, 1);
    send_frame(HDR_FIRST_RST, HDR_SECOND_RST, 8'h00, 16'h0000, 1'b1, FRAME_LEN, 0);

    // Random traffic under the reset headers, with one long result hold-off.
    hold_req = 1'b1;
    random_phase(PHASE_BEATS);

    // Header extremes, a write to an unused index, a random pair, then back
    // to the reset values.
    new_setting(8'h00, 8'hFF);
    random_phase(PHASE_BEATS);
    settle();
    cfg_write(REG_SPARE, 8'($urandom));
    new_setting(8'hFF, 8'h00);
    random_phase(PHASE_BEATS);
    new_setting(8'($urandom), 8'($urandom));
    random_phase(PHASE_BEATS);
    new_setting(HDR_FIRST_RST, HDR_SECOND_RST);
    random_phase(PHASE_BEATS);

    settle();
    $display("Sent %0d byte beats over %0d header settings.", beats_sent, settings_used);
    $display("Checked %0d frames: %0d good (%0d with drive update), %0d bad CRC.",
             sb.checked, sb.good_seen, sb.drive_seen, sb.bad_seen);
    if (sb.errors == 0) begin
      $display("crc8_button_frame_deframer regression: pass");
    end else begin
      $display("crc8_button_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
